@@ design/byte_ring_queue_multi_byte_macros.svh @@
// Assertion helpers used by the queue controller.
// Each expects clk and arst_n in the scope where it is used.
`ifndef BYTE_RING_QUEUE_MULTI_BYTE_MACROS_SVH
`define BYTE_RING_QUEUE_MULTI_BYTE_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge out of reset
`define BRQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge out of reset
`define BRQ_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define BRQ_ASSERT(lbl, prop, msg)
`define BRQ_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

@@ design/brq_pkg.sv @@
package brq_pkg;

	// Store geometry: one byte-wide bank per lane
	localparam int STORE_DEPTH = 256;
	localparam int LANES       = 8;
	localparam int LANE_W      = $clog2(LANES);
	localparam int PTR_W       = $clog2(STORE_DEPTH);
	localparam int ROWS        = STORE_DEPTH / LANES;
	localparam int ROW_W       = PTR_W - LANE_W;

	// Field widths
	localparam int CAP_W   = 9;
	localparam int CNT_W   = 4;
	localparam int BYTE_W  = 8;
	localparam int DATA_W  = BYTE_W * LANES;
	localparam int AVAIL_W = PTR_W + 1;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(STORE_DEPTH);
	localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	// Request to one bank
	typedef struct packed {
		logic              en;
		logic              we;
		logic [ROW_W-1:0]  row;
		logic [BYTE_W-1:0] wdata;
	} bank_req_t;

	// Registered result status, valid in the cycle after the transaction is accepted
	typedef struct packed {
		logic              done;
		logic              failed;
		logic [CNT_W-1:0]  count;
		logic              is_read;
		logic [LANE_W-1:0] rot;
	} rsp_t;

endpackage

@@ design/brq_bank.sv @@
module brq_bank #(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int WIDTH  = 8
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port, registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

@@ design/brq_ctrl.sv @@
`include "byte_ring_queue_multi_byte_macros.svh"

module brq_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         cfg_we,
	input  logic [brq_pkg::CAP_W-1:0]    cfg_wdata,
	input  logic                         opcode,
	input  logic [brq_pkg::CNT_W-1:0]    min_count,
	input  logic [brq_pkg::CNT_W-1:0]    max_count,
	input  logic [brq_pkg::DATA_W-1:0]   write_bytes,
	output brq_pkg::bank_req_t           bank_req [brq_pkg::LANES],
	output brq_pkg::rsp_t                rsp
);
	import brq_pkg::*;

	logic [CAP_W-1:0]   cap_q;
	logic [PTR_W-1:0]   fill_q;
	logic [PTR_W-1:0]   wptr_q;
	logic [PTR_W-1:0]   rptr_q;

	logic [CAP_W-1:0]   len;
	logic [AVAIL_W-1:0] avail;
	logic [CNT_W-1:0]   max_sat;
	logic [CNT_W-1:0]   n;
	logic               is_read;
	logic               fail;
	logic               move;
	logic [PTR_W-1:0]   ptr;

	// Ring length in use, clamped to the store
	always_comb begin
		if (cap_q < CAP_MIN) begin
			len = CAP_MIN;
		end else if (cap_q > CAP_RESET) begin
			len = CAP_RESET;
		end else begin
			len = cap_q;
		end
	end

	// Space or fill available, transfer size
	always_comb begin
		is_read = (op_t'(opcode) == OP_READ);
		if (is_read) begin
			avail = AVAIL_W'(fill_q);
		end else begin
			avail = AVAIL_W'(len - CAP_W'(1) - CAP_W'(fill_q));
		end
		fail    = avail < AVAIL_W'(min_count);
		max_sat = (max_count > CNT_W'(LANES)) ? CNT_W'(LANES) : max_count;
		n       = (AVAIL_W'(max_sat) < avail) ? max_sat : CNT_W'(avail);
		move    = accept && !fail;
		ptr     = is_read ? rptr_q : wptr_q;
	end

	// Bank requests: bank b serves lane (b - ptr) mod LANES
	always_comb begin
		logic [LANE_W-1:0] lane;
		for (int b = 0; b < LANES; b++) begin
			lane = LANE_W'(b) - ptr[LANE_W-1:0];
			bank_req[b].en    = move && is_read || move && (CNT_W'(lane) < n);
			bank_req[b].we    = !is_read && (CNT_W'(lane) < n);
			bank_req[b].row   = ROW_W'(PTR_W'(ptr + PTR_W'(lane)) >> LANE_W);
			bank_req[b].wdata = write_bytes[BYTE_W*lane +: BYTE_W];
		end
	end

	// Queue state; a configuration write empties the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			fill_q <= '0;
			wptr_q <= '0;
			rptr_q <= '0;
		end else if (cfg_we) begin
			cap_q  <= cfg_wdata;
			fill_q <= '0;
			wptr_q <= '0;
			rptr_q <= '0;
		end else if (move) begin
			if (is_read) begin
				fill_q <= fill_q - PTR_W'(n);
				rptr_q <= rptr_q + PTR_W'(n);
			end else begin
				fill_q <= fill_q + PTR_W'(n);
				wptr_q <= wptr_q + PTR_W'(n);
			end
		end
	end

	// Result status register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp <= '0;
		end else begin
			rsp.done    <= accept;
			rsp.failed  <= fail;
			rsp.count   <= fail ? '0 : n;
			rsp.is_read <= is_read;
			rsp.rot     <= rptr_q[LANE_W-1:0];
		end
	end

	`BRQ_ASSERT(a_fill_below_len, CAP_W'(fill_q) < len, "fill reached ring length")
	`BRQ_ASSERT(a_done_follows, accept |=> rsp.done, "accepted transaction gave no result")
	`BRQ_ASSERT(a_no_spurious, !accept |=> !rsp.done, "result without a transaction")
	`BRQ_ASSERT_NEVER(a_fail_count, rsp.done && rsp.failed && rsp.count != '0,
		"failed transaction reports moved bytes")
	`BRQ_ASSERT(a_write_fill, move && !is_read && !cfg_we |=> fill_q == $past(fill_q + PTR_W'(n)),
		"write did not grow fill by moved count")

endmodule

@@ design/byte_ring_queue_multi_byte.sv @@
// The result strobe done rises in the cycle after a transaction is accepted.
// Throughput: one transaction per cycle; busy is always low. Eight byte-wide
// banks, one per lane, each with one port, carry all the bytes of a transaction.
// Reset (arst_n low, asynchronous): queue empty, capacity 256, no result pending.
// The receiver cannot stall; each result is shown for exactly one cycle.
module byte_ring_queue_multi_byte (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	output logic                         done,
	input  logic                         cfg_we,
	input  logic [brq_pkg::CAP_W-1:0]    cfg_wdata,
	input  logic                         opcode,
	input  logic [brq_pkg::CNT_W-1:0]    min_count,
	input  logic [brq_pkg::CNT_W-1:0]    max_count,
	input  logic [brq_pkg::DATA_W-1:0]   write_bytes,
	output logic                         failed,
	output logic [brq_pkg::CNT_W-1:0]    moved_count,
	output logic [brq_pkg::DATA_W-1:0]   read_bytes
);
	import brq_pkg::*;

	bank_req_t         bank_req [LANES];
	rsp_t              rsp;
	logic [BYTE_W-1:0] bank_rdata [LANES];
	logic              accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	brq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.opcode      (opcode),
		.min_count   (min_count),
		.max_count   (max_count),
		.write_bytes (write_bytes),
		.bank_req    (bank_req),
		.rsp         (rsp)
	);

	// One bank per lane
	for (genvar b = 0; b < LANES; b++) begin : g_bank
		brq_bank #(
			.DEPTH  (ROWS),
			.ADDR_W (ROW_W),
			.WIDTH  (BYTE_W)
		) u_bank (
			.clk   (clk),
			.en    (bank_req[b].en),
			.we    (bank_req[b].we),
			.addr  (bank_req[b].row),
			.wdata (bank_req[b].wdata),
			.rdata (bank_rdata[b])
		);
	end

	// Rotate banks back into lane order, zero unused lanes
	always_comb begin
		logic [LANE_W-1:0] idx;
		for (int i = 0; i < LANES; i++) begin
			idx = rsp.rot + LANE_W'(i);
			if (rsp.is_read && (CNT_W'(i) < rsp.count)) begin
				read_bytes[BYTE_W*i +: BYTE_W] = bank_rdata[idx];
			end else begin
				read_bytes[BYTE_W*i +: BYTE_W] = '0;
			end
		end
	end

	assign done        = rsp.done;
	assign failed      = rsp.failed;
	assign moved_count = rsp.count;

endmodule
